// ===== src/tpwb_pkg.sv =====
package tpwb_pkg;

   // Address and size width of every window field
   localparam int unsigned ADDR_W = 32;

   // Data block limits and fixed window sizes
   localparam logic [ADDR_W-1:0] MIN_DATA_BLOCK   = 32'd1024;
   localparam logic [ADDR_W-1:0] MAX_DATA_BLOCK   = 32'd65536;
   localparam logic [ADDR_W-1:0] CHIP_RAM_BYTES   = 32'd131072;
   localparam logic [ADDR_W-1:0] SHARED_RAM_BYTES = 32'd1024;

   // Smallest and largest window the image rounding may produce
   localparam logic [ADDR_W-1:0] MIN_WINDOW = 32'd32;
   localparam logic [ADDR_W-1:0] MAX_WINDOW = 32'h8000_0000;

   // Register indexes on the configuration port
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_POOL_BASE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_POOL_SIZE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_POOL_BASE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_POOL_SIZE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_CODE_BASE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_CODE_SIZE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLBACK_DATA_BASE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARED_RAM_BASE    = 3'd7;

   // Window slots
   localparam logic [1:0] SLOT_CODE   = 2'd0;
   localparam logic [1:0] SLOT_DATA   = 2'd1;
   localparam logic [1:0] SLOT_SHARED = 2'd2;

   // Window kinds
   localparam logic [1:0] KIND_ROM  = 2'd0;
   localparam logic [1:0] KIND_RAMX = 2'd1;
   localparam logic [1:0] KIND_RAM  = 2'd2;

   // Power of two at or above n, at least MIN_WINDOW, capped at MAX_WINDOW
   function automatic logic [ADDR_W-1:0] pow2_at_least(input logic [ADDR_W-1:0] n);
      logic [ADDR_W-1:0] v;
      v = MIN_WINDOW;
      for (int i = 0; i < ADDR_W; i++) begin
         if (v < n && v < MAX_WINDOW) begin
            v = v << 1;
         end
      end
      return v;
   endfunction

   // Whole-chip fallback window size, settled at elaboration
   localparam logic [ADDR_W-1:0] CHIP_WINDOW = pow2_at_least(CHIP_RAM_BYTES);

   function automatic logic is_pow2(input logic [ADDR_W-1:0] v);
      return (v != '0) && ((v & (v - 1'b1)) == '0);
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CLASS,
      ST_GROW,
      ST_EMIT_CODE,
      ST_EMIT_DATA,
      ST_EMIT_SHARED
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic classify;
      logic grow;
      logic emit_code;
      logic emit_data;
      logic emit_shared;
   } cmd_type;

   typedef struct packed {
      logic grow_more;
   } status_type;

endpackage

// ===== src/tpwb_ctrl.sv =====
module tpwb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  tpwb_pkg::status_type status,
   output logic                busy,
   output tpwb_pkg::cmd_type   cmd
);
   import tpwb_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Hold the sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance through the steps of one task
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP:        state_in = ST_CLASS;
         ST_CLASS:       state_in = ST_GROW;
         ST_GROW: begin
            if (!status.grow_more) begin
               state_in = ST_EMIT_CODE;
            end
         end
         ST_EMIT_CODE:   state_in = ST_EMIT_DATA;
         ST_EMIT_DATA:   state_in = ST_EMIT_SHARED;
         ST_EMIT_SHARED: state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // Drive datapath commands from the state
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_PREP:        cmd.prep        = 1'b1;
         ST_CLASS:       cmd.classify    = 1'b1;
         ST_GROW:        cmd.grow        = status.grow_more;
         ST_EMIT_CODE:   cmd.emit_code   = 1'b1;
         ST_EMIT_DATA:   cmd.emit_data   = 1'b1;
         ST_EMIT_SHARED: cmd.emit_shared = 1'b1;
         default:        busy            = 1'b0;
      endcase
   end

`ifndef SYNTHESIS
   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_IDLE)
      else $error("word accepted while busy");
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_code |=> cmd.emit_data ##1 cmd.emit_shared)
      else $error("window emission out of order");
   a_grow_stays: assert property (@(posedge clock) disable iff (reset)
      cmd.grow |=> state_ff == ST_GROW)
      else $error("left growth while still doubling");
`endif

endmodule

// ===== src/tpwb_datapath.sv =====
module tpwb_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tpwb_pkg::cmd_type                      cmd,
   output tpwb_pkg::status_type                   status,
   input  logic                                   csr_write_en,
   input  logic [tpwb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tpwb_pkg::ADDR_W-1:0]            csr_wdata,
   input  logic [tpwb_pkg::ADDR_W-1:0]            req_code_start,
   input  logic [tpwb_pkg::ADDR_W-1:0]            req_code_span,
   input  logic [tpwb_pkg::ADDR_W-1:0]            req_data_start,
   input  logic [tpwb_pkg::ADDR_W-1:0]            req_data_size,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_region_slot,
   output logic [tpwb_pkg::ADDR_W-1:0]            rsp_region_base,
   output logic [tpwb_pkg::ADDR_W-1:0]            rsp_region_size,
   output logic [1:0]                             rsp_region_kind,
   output logic                                   rsp_region_enabled,
   output logic                                   rsp_last_region
);
   import tpwb_pkg::*;

   // Configuration registers
   logic [ADDR_W-1:0] image_pool_base_ff, image_pool_size_ff;
   logic [ADDR_W-1:0] ram_pool_base_ff, ram_pool_size_ff;
   logic [ADDR_W-1:0] kernel_code_base_ff, kernel_code_size_ff;
   logic [ADDR_W-1:0] fallback_data_base_ff, shared_ram_base_ff;

   // Latched task word
   logic [ADDR_W-1:0] code_start_ff, code_span_ff, data_start_ff, data_size_ff;

   // 33-bit ends of pools and blocks
   logic [ADDR_W:0] ram_end_ff, img_end_ff, code_end_ff, data_end_ff;

   // Classification flags
   logic code_ram_ff, code_img_ff, ram_code_ok_ff, data_ram_ff, data_ok_ff;

   // Image window size under growth
   logic [ADDR_W-1:0] win_size_ff, win_size_in;
   logic [ADDR_W-1:0] win_base;
   logic [ADDR_W:0]   win_end;

   // Settled windows
   logic [ADDR_W-1:0] code_base_ff, code_size_ff, data_base_ff, data_size_w_ff;
   logic [ADDR_W-1:0] code_base_in, code_size_in, data_base_in, data_size_in;
   logic [1:0]        data_kind;
   logic [ADDR_W:0]   data_win_end;
   logic              shared_free;

   // Output word registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        slot_ff, slot_in, kind_ff, kind_in;
   logic [ADDR_W-1:0] base_ff, base_in, size_ff, size_in;
   logic              last_ff, last_in;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_pool_base_ff    <= '0;
         image_pool_size_ff    <= '0;
         ram_pool_base_ff      <= '0;
         ram_pool_size_ff      <= '0;
         kernel_code_base_ff   <= '0;
         kernel_code_size_ff   <= '0;
         fallback_data_base_ff <= '0;
         shared_ram_base_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_POOL_BASE:    image_pool_base_ff    <= csr_wdata;
            CSR_IMAGE_POOL_SIZE:    image_pool_size_ff    <= csr_wdata;
            CSR_RAM_POOL_BASE:      ram_pool_base_ff      <= csr_wdata;
            CSR_RAM_POOL_SIZE:      ram_pool_size_ff      <= csr_wdata;
            CSR_KERNEL_CODE_BASE:   kernel_code_base_ff   <= csr_wdata;
            CSR_KERNEL_CODE_SIZE:   kernel_code_size_ff   <= csr_wdata;
            CSR_FALLBACK_DATA_BASE: fallback_data_base_ff <= csr_wdata;
            CSR_SHARED_RAM_BASE:    shared_ram_base_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Latch the task word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_start_ff <= req_code_start;
         code_span_ff  <= req_code_span;
         data_start_ff <= req_data_start;
         data_size_ff  <= req_data_size;
      end
   end

   // Form pool and block ends
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         ram_end_ff  <= {1'b0, ram_pool_base_ff} + {1'b0, ram_pool_size_ff};
         img_end_ff  <= {1'b0, image_pool_base_ff} + {1'b0, image_pool_size_ff};
         code_end_ff <= {1'b0, code_start_ff} + {1'b0, code_span_ff};
         data_end_ff <= {1'b0, data_start_ff} + {1'b0, data_size_ff};
      end
   end

   // Classify code and data placement
   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         code_ram_ff <= code_start_ff >= ram_pool_base_ff &&
                        {1'b0, code_start_ff} < ram_end_ff;
         code_img_ff <= !(code_start_ff >= ram_pool_base_ff &&
                          {1'b0, code_start_ff} < ram_end_ff) &&
                        code_start_ff >= image_pool_base_ff &&
                        {1'b0, code_start_ff} < img_end_ff &&
                        code_span_ff != '0 && code_end_ff <= img_end_ff;
         ram_code_ok_ff <= is_pow2(code_span_ff) &&
                           (code_start_ff & (code_span_ff - 1'b1)) == '0 &&
                           code_end_ff <= ram_end_ff;
         data_ram_ff <= data_start_ff >= ram_pool_base_ff &&
                        {1'b0, data_start_ff} < ram_end_ff;
         data_ok_ff  <= data_size_ff >= MIN_DATA_BLOCK &&
                        data_size_ff <= MAX_DATA_BLOCK &&
                        is_pow2(data_size_ff) &&
                        (data_start_ff & (data_size_ff - 1'b1)) == '0 &&
                        data_end_ff <= ram_end_ff;
      end
   end

   // Grow the image window one doubling a cycle
   assign win_base = code_start_ff & ~(win_size_ff - 1'b1);
   assign win_end  = {1'b0, win_base} + {1'b0, win_size_ff};
   assign status.grow_more = code_img_ff && !win_size_ff[ADDR_W-1] &&
                             (win_size_ff < code_span_ff || win_end < code_end_ff);

   always_comb begin
      win_size_in = win_size_ff;
      if (cmd.classify) begin
         win_size_in = MIN_WINDOW;
      end else if (cmd.grow) begin
         win_size_in = win_size_ff << 1;
      end
   end

   always_ff @(posedge clock) begin
      win_size_ff <= win_size_in;
   end

   // Settle the code window
   always_comb begin
      code_base_in = '0;
      code_size_in = '0;
      if (code_ram_ff) begin
         if (ram_code_ok_ff) begin
            code_base_in = code_start_ff;
            code_size_in = code_span_ff;
         end
      end else if (code_img_ff) begin
         if (win_end >= code_end_ff) begin
            code_base_in = win_base;
            code_size_in = win_size_ff;
         end
      end else begin
         code_base_in = kernel_code_base_ff;
         code_size_in = kernel_code_size_ff;
      end
      if (code_size_in == '0) begin
         code_base_in = '0;
      end
   end

   // Settle the data window
   always_comb begin
      data_base_in = '0;
      data_size_in = '0;
      if (data_ram_ff) begin
         if (data_ok_ff) begin
            data_base_in = data_start_ff;
            data_size_in = data_size_ff;
         end
      end else begin
         data_base_in = fallback_data_base_ff;
         data_size_in = CHIP_WINDOW;
      end
      if (data_size_in == '0) begin
         data_base_in = '0;
      end
      data_kind = (code_ram_ff && data_base_in == code_base_ff &&
                   data_size_in == code_size_ff) ? KIND_RAMX : KIND_RAM;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_code) begin
         code_base_ff <= code_base_in;
         code_size_ff <= code_size_in;
      end
      if (cmd.emit_data) begin
         data_base_ff   <= data_base_in;
         data_size_w_ff <= data_size_in;
      end
   end

   // Shared window is free unless its base falls in the data window
   assign data_win_end = {1'b0, data_base_ff} + {1'b0, data_size_w_ff};
   assign shared_free  = shared_ram_base_ff < data_base_ff ||
                         {1'b0, shared_ram_base_ff} >= data_win_end;

   // Build the output word
   always_comb begin
      rsp_valid_in = 1'b0;
      slot_in      = SLOT_CODE;
      base_in      = '0;
      size_in      = '0;
      kind_in      = KIND_ROM;
      last_in      = 1'b0;
      if (cmd.emit_code) begin
         rsp_valid_in = 1'b1;
         slot_in      = SLOT_CODE;
         base_in      = code_base_in;
         size_in      = code_size_in;
         kind_in      = code_ram_ff ? KIND_RAMX : KIND_ROM;
      end else if (cmd.emit_data) begin
         rsp_valid_in = 1'b1;
         slot_in      = SLOT_DATA;
         base_in      = data_base_in;
         size_in      = data_size_in;
         kind_in      = data_kind;
      end else if (cmd.emit_shared) begin
         rsp_valid_in = 1'b1;
         slot_in      = SLOT_SHARED;
         kind_in      = KIND_RAM;
         last_in      = 1'b1;
         if (shared_free) begin
            base_in = shared_ram_base_ff;
            size_in = SHARED_RAM_BYTES;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      base_ff <= base_in;
      size_ff <= size_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_region_slot    = slot_ff;
   assign rsp_region_base    = base_ff;
   assign rsp_region_size    = size_ff;
   assign rsp_region_kind    = kind_ff;
   assign rsp_region_enabled = size_ff != '0;
   assign rsp_last_region    = last_ff;

`ifndef SYNTHESIS
   a_grow_pow2: assert property (@(posedge clock) disable iff (reset)
      cmd.grow |-> $onehot(win_size_ff))
      else $error("image window size not a power of two");
   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && size_ff == '0 |-> base_ff == '0)
      else $error("disabled window carries a base");
   a_last_is_shared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> slot_ff == SLOT_SHARED && $past(rsp_valid_ff))
      else $error("last word not the shared window");
   a_data_after_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && slot_ff == SLOT_DATA |-> $past(slot_ff) == SLOT_CODE)
      else $error("data window not preceded by code window");
`endif

endmodule

// ===== src/task_protection_window_builder_top.sv =====
// Builds the three protection windows of one task: code (slot 0), data (slot 1)
// and shared RAM (slot 2). Raise start with the task word while busy is low;
// the word is taken at that edge. The three windows follow in slot order on
// consecutive cycles, each shown for one cycle with rsp_valid, the third with
// rsp_last_region; they cannot be held off. While busy is high no new task word
// is taken. The image-pool code window is grown by g doublings (0 to 26),
// one per cycle through a single 33-bit add and compare, starting from 32 bytes.
// Registers are to be written through the csr_ port only while the block is idle;
// the block itself does not enforce this.
module task_protection_window_builder_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tpwb_pkg::ADDR_W-1:0]    req_code_start,
   input  logic [tpwb_pkg::ADDR_W-1:0]    req_code_span,
   input  logic [tpwb_pkg::ADDR_W-1:0]    req_data_start,
   input  logic [tpwb_pkg::ADDR_W-1:0]    req_data_size,
   input  logic                           csr_write_en,
   input  logic [tpwb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpwb_pkg::ADDR_W-1:0]    csr_wdata,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_region_slot,
   output logic [tpwb_pkg::ADDR_W-1:0]    rsp_region_base,
   output logic [tpwb_pkg::ADDR_W-1:0]    rsp_region_size,
   output logic [1:0]                     rsp_region_kind,
   output logic                           rsp_region_enabled,
   output logic                           rsp_last_region
);
   import tpwb_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequence the steps of one task
   tpwb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // Hold registers and compute windows
   tpwb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_code_start     (req_code_start),
      .req_code_span      (req_code_span),
      .req_data_start     (req_data_start),
      .req_data_size      (req_data_size),
      .rsp_valid          (rsp_valid),
      .rsp_region_slot    (rsp_region_slot),
      .rsp_region_base    (rsp_region_base),
      .rsp_region_size    (rsp_region_size),
      .rsp_region_kind    (rsp_region_kind),
      .rsp_region_enabled (rsp_region_enabled),
      .rsp_last_region    (rsp_last_region)
   );

endmodule

// ===== tb/tpwb_window_checker.sv =====
`timescale 1ns / 1ps

module tpwb_window_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [tpwb_pkg::ADDR_W-1:0]    req_code_start,
   input  logic [tpwb_pkg::ADDR_W-1:0]    req_code_span,
   input  logic [tpwb_pkg::ADDR_W-1:0]    req_data_start,
   input  logic [tpwb_pkg::ADDR_W-1:0]    req_data_size,
   input  logic                           csr_write_en,
   input  logic [tpwb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpwb_pkg::ADDR_W-1:0]    csr_wdata,
   input  logic                           rsp_valid,
   input  logic [1:0]                     rsp_region_slot,
   input  logic [tpwb_pkg::ADDR_W-1:0]    rsp_region_base,
   input  logic [tpwb_pkg::ADDR_W-1:0]    rsp_region_size,
   input  logic [1:0]                     rsp_region_kind,
   input  logic                           rsp_region_enabled,
   input  logic                           rsp_last_region,
   output int                             failures,
   output int                             pending
);
   import tpwb_pkg::*;

   // Largest window the image rounding may grow to, at 33 bits
   localparam logic [32:0] WINDOW_CAP = 33'h0_8000_0000;

   typedef struct packed {
      logic [1:0]  slot;
      logic [31:0] base;
      logic [31:0] size;
      logic [1:0]  kind;
      logic        enabled;
      logic        is_last;
   } window_type;

   window_type expected_windows[$];
   window_type want;

   // Shadow copy of the register file
   logic [31:0] img_base, img_size, rpool_base, rpool_size;
   logic [31:0] kernel_base, kernel_size, fallback_base, shared_base;

   // Smallest power of two at or above n, never below 32, never above the cap
   function automatic logic [32:0] window_ceil(input logic [32:0] n);
      logic [32:0] v;
      v = 33'd32;
      while (v < n && v < WINDOW_CAP) v = v << 1;
      return v;
   endfunction

   function automatic logic single_bit(input logic [32:0] v);
      return (v != 33'd0) && ((v & (v - 33'd1)) == 33'd0);
   endfunction

   // A zero-sized window is reported disabled with base and size cleared
   function automatic void queue_window(input logic [1:0] slot, input logic [32:0] base,
                                        input logic [32:0] size, input logic [1:0] kind,
                                        input logic is_last);
      window_type w;
      w.slot    = slot;
      w.enabled = (size != 33'd0);
      w.base    = w.enabled ? base[31:0] : 32'd0;
      w.size    = w.enabled ? size[31:0] : 32'd0;
      w.kind    = kind;
      w.is_last = is_last;
      expected_windows.push_back(w);
   endfunction

   // Work out the code, data and shared windows of one task word
   function automatic void predict_windows(input logic [31:0] code_start,
                                           input logic [31:0] code_span,
                                           input logic [31:0] data_start,
                                           input logic [31:0] data_size);
      logic [32:0] cs, cn, ds, dn, rb, re, ib, ie;
      logic [32:0] cb, cz, db, dz, sz, b, sh;
      logic        code_ram;
      logic [1:0]  dkind;
      cs = {1'b0, code_start};
      cn = {1'b0, code_span};
      ds = {1'b0, data_start};
      dn = {1'b0, data_size};
      rb = {1'b0, rpool_base};
      re = rb + {1'b0, rpool_size};
      ib = {1'b0, img_base};
      ie = ib + {1'b0, img_size};
      sh = {1'b0, shared_base};
      cb = '0;
      cz = '0;
      db = '0;
      dz = '0;

      // Code: exact buddy block in RAM, rounded window in the image pool, else kernel
      code_ram = (cs >= rb) && (cs < re);
      if (code_ram) begin
         if (single_bit(cn) && ((cs & (cn - 33'd1)) == 33'd0) && (cs + cn <= re)) begin
            cb = cs;
            cz = cn;
         end
      end else if (cs >= ib && cs < ie && cn != 33'd0 && cs + cn <= ie) begin
         sz = window_ceil(cn);
         b  = cs & ~(sz - 33'd1);
         while ((b + sz < cs + cn) && (sz < WINDOW_CAP)) begin
            sz = sz << 1;
            b  = cs & ~(sz - 33'd1);
         end
         if (b + sz >= cs + cn) begin
            cb = b;
            cz = sz;
         end
      end else begin
         cb = {1'b0, kernel_base};
         cz = {1'b0, kernel_size};
      end
      queue_window(SLOT_CODE, cb, cz, code_ram ? KIND_RAMX : KIND_ROM, 1'b0);

      // Data: qualifying buddy block in the pool, disabled otherwise, whole chip outside
      if (ds >= rb && ds < re) begin
         if (dn >= {1'b0, MIN_DATA_BLOCK} && dn <= {1'b0, MAX_DATA_BLOCK} &&
             single_bit(dn) && ((ds & (dn - 33'd1)) == 33'd0) && (ds + dn <= re)) begin
            db = ds;
            dz = dn;
         end
      end else begin
         db = {1'b0, fallback_base};
         dz = window_ceil({1'b0, CHIP_RAM_BYTES});
      end
      if (dz == 33'd0) db = '0;
      if (cz == 33'd0) cb = '0;
      dkind = (code_ram && db == cb && dz == cz) ? KIND_RAMX : KIND_RAM;
      queue_window(SLOT_DATA, db, dz, dkind, 1'b0);

      // Shared: drop when the data window already covers its base
      if (sh < db || sh >= db + dz) begin
         queue_window(SLOT_SHARED, sh, {1'b0, SHARED_RAM_BYTES}, KIND_RAM, 1'b1);
      end else begin
         queue_window(SLOT_SHARED, 33'd0, 33'd0, KIND_RAM, 1'b1);
      end
   endfunction

   task automatic report_field(input string name, input logic [31:0] expected_value,
                               input logic [31:0] actual_value);
      if (expected_value !== actual_value) begin
         $display("%0t: window %s mismatch, expected %0h, actual %0h",
                  $time, name, expected_value, actual_value);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_windows.delete();
         img_base      = '0;
         img_size      = '0;
         rpool_base    = '0;
         rpool_size    = '0;
         kernel_base   = '0;
         kernel_size   = '0;
         fallback_base = '0;
         shared_base   = '0;
      end else begin
         // Check an emitted window word against the oldest prediction
         if (rsp_valid !== 1'b0) begin
            if (expected_windows.size() == 0) begin
               $display("%0t: window word with none expected, expected none, actual slot %0h",
                        $time, rsp_region_slot);
               failures++;
            end else begin
               want = expected_windows.pop_front();
               report_field("slot", {30'd0, want.slot}, {30'd0, rsp_region_slot});
               report_field("base", want.base, rsp_region_base);
               report_field("size", want.size, rsp_region_size);
               report_field("kind", {30'd0, want.kind}, {30'd0, rsp_region_kind});
               report_field("enabled", {31'd0, want.enabled}, {31'd0, rsp_region_enabled});
               report_field("last", {31'd0, want.is_last}, {31'd0, rsp_last_region});
            end
         end

         // Track register writes
         if (csr_write_en) begin
            case (csr_index)
               CSR_IMAGE_POOL_BASE:    img_base      = csr_wdata;
               CSR_IMAGE_POOL_SIZE:    img_size      = csr_wdata;
               CSR_RAM_POOL_BASE:      rpool_base    = csr_wdata;
               CSR_RAM_POOL_SIZE:      rpool_size    = csr_wdata;
               CSR_KERNEL_CODE_BASE:   kernel_base   = csr_wdata;
               CSR_KERNEL_CODE_SIZE:   kernel_size   = csr_wdata;
               CSR_FALLBACK_DATA_BASE: fallback_base = csr_wdata;
               CSR_SHARED_RAM_BASE:    shared_base   = csr_wdata;
               default: ;
            endcase
         end

         // Predict on each accepted task word
         if (start === 1'b1 && busy === 1'b0) begin
            predict_windows(req_code_start, req_code_span, req_data_start, req_data_size);
         end
      end
      pending = expected_windows.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import tpwb_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int TIMEOUT_NS   = 400_000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [ADDR_W-1:0]    req_code_start = '0;
   logic [ADDR_W-1:0]    req_code_span  = '0;
   logic [ADDR_W-1:0]    req_data_start = '0;
   logic [ADDR_W-1:0]    req_data_size  = '0;
   logic                 csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [ADDR_W-1:0]    csr_wdata      = '0;
   logic                 rsp_valid;
   logic [1:0]           rsp_region_slot;
   logic [ADDR_W-1:0]    rsp_region_base;
   logic [ADDR_W-1:0]    rsp_region_size;
   logic [1:0]           rsp_region_kind;
   logic                 rsp_region_enabled;
   logic                 rsp_last_region;
   int                   failures;
   int                   pending;

   // Current setting, kept to shape random task words
   logic [31:0] img_base = '0, img_size = '0, rpool_base = '0, rpool_size = '0;
   // Set for stretches with no idling on the sender
   logic        steady = 1'b0;

   always #1 clock = ~clock;

   task_protection_window_builder_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_code_start     (req_code_start),
      .req_code_span      (req_code_span),
      .req_data_start     (req_data_start),
      .req_data_size      (req_data_size),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_region_slot    (rsp_region_slot),
      .rsp_region_base    (rsp_region_base),
      .rsp_region_size    (rsp_region_size),
      .rsp_region_kind    (rsp_region_kind),
      .rsp_region_enabled (rsp_region_enabled),
      .rsp_last_region    (rsp_last_region)
   );

   tpwb_window_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_code_start     (req_code_start),
      .req_code_span      (req_code_span),
      .req_data_start     (req_data_start),
      .req_data_size      (req_data_size),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_region_slot    (rsp_region_slot),
      .rsp_region_base    (rsp_region_base),
      .rsp_region_size    (rsp_region_size),
      .rsp_region_kind    (rsp_region_kind),
      .rsp_region_enabled (rsp_region_enabled),
      .rsp_last_region    (rsp_last_region),
      .failures           (failures),
      .pending            (pending)
   );

   // Drop start and wait until every window has come out and the block is idle
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy !== 1'b0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
   endtask

   task automatic program_setting(input logic [31:0] ib, input logic [31:0] isz,
                                  input logic [31:0] rb, input logic [31:0] rsz,
                                  input logic [31:0] kb, input logic [31:0] ksz,
                                  input logic [31:0] fb, input logic [31:0] sb);
      settle();
      write_reg(CSR_IMAGE_POOL_BASE, ib);
      write_reg(CSR_IMAGE_POOL_SIZE, isz);
      write_reg(CSR_RAM_POOL_BASE, rb);
      write_reg(CSR_RAM_POOL_SIZE, rsz);
      write_reg(CSR_KERNEL_CODE_BASE, kb);
      write_reg(CSR_KERNEL_CODE_SIZE, ksz);
      write_reg(CSR_FALLBACK_DATA_BASE, fb);
      write_reg(CSR_SHARED_RAM_BASE, sb);
      csr_write_en <= 1'b0;
      img_base   = ib;
      img_size   = isz;
      rpool_base = rb;
      rpool_size = rsz;
   endtask

   // Mostly back to back, often a short pause, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one task word and hold it until the block takes it
   task automatic send_job(input logic [31:0] cs, input logic [31:0] cn,
                           input logic [31:0] ds, input logic [31:0] dn);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_code_start <= cs;
      req_code_span  <= cn;
      req_data_start <= ds;
      req_data_size  <= dn;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Power-of-two block in the RAM pool, aligned, sometimes running past its end
   function automatic void pick_block(input int lo_k, input int hi_k,
                                      output logic [31:0] addr, output logic [31:0] size);
      int          k;
      logic [32:0] slots, offset;
      k      = $urandom_range(lo_k, hi_k);
      size   = 32'd1 << k;
      slots  = ({1'b0, rpool_size} >> k) + 33'd1;
      offset = ({1'b0, $urandom} % slots) << k;
      addr   = rpool_base + offset[31:0];
   endfunction

   task automatic random_setting();
      logic [31:0] rb, rsz, ib, isz, kb, ksz, fb, sb;
      rb  = $urandom & 32'hFFF0_0000;
      rsz = 32'd1 << $urandom_range(16, 20);
      if ($urandom_range(0, 3) == 0) rsz = rsz + $urandom_range(1, 32'hFFFF);
      ib  = $urandom & 32'h7FFF_FFF0;
      isz = 32'd1 << $urandom_range(12, 24);
      if ($urandom_range(0, 3) == 0) isz = isz + $urandom_range(1, 4095);
      kb  = $urandom;
      case ($urandom_range(0, 2))
         0:       ksz = 32'd0;
         1:       ksz = 32'd1 << $urandom_range(5, 31);
         default: ksz = $urandom;
      endcase
      fb  = $urandom;
      // Put the shared base where a data window may cover it
      case ($urandom_range(0, 3))
         0, 1:    sb = rb + ($urandom % rsz);
         2:       sb = fb + $urandom_range(0, 32'h1FFFF);
         default: sb = $urandom;
      endcase
      program_setting(ib, isz, rb, rsz, kb, ksz, fb, sb);
   endtask

   task automatic random_job();
      logic [31:0] cs, cn, ds, dn, rest;
      // Code: buddy block, image placement, kernel task or noise
      case ($urandom_range(0, 9))
         0, 1, 2, 3: pick_block(5, 16, cs, cn);
         4, 5, 6: begin
            cs   = img_base + ($urandom % img_size);
            rest = img_base + img_size - cs;
            case ($urandom_range(0, 3))
               0, 1:    cn = $urandom_range(1, (rest < 32'd4096) ? rest : 32'd4096);
               2:       cn = $urandom_range(1, rest);
               default: cn = rest + $urandom_range(0, 2);
            endcase
         end
         7: begin
            cs = '0;
            cn = $urandom_range(0, 32'hFFFF);
         end
         default: begin
            cs = $urandom;
            cn = $urandom >> $urandom_range(0, 31);
         end
      endcase
      // Data: buddy block, out-of-range block, loose pool address, same as code or noise
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: pick_block(10, 16, ds, dn);
         5: pick_block(8, 17, ds, dn);
         6: begin
            ds = rpool_base + ($urandom % rpool_size);
            dn = $urandom_range(0, 32'h11000);
         end
         7: begin
            ds = cs;
            dn = cn;
         end
         default: begin
            ds = $urandom;
            dn = $urandom;
         end
      endcase
      send_job(cs, cn, ds, dn);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: empty pools, zero kernel window
      send_job(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_job(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Typical layout
      program_setting(32'h0800_0000, 32'h0010_0000, 32'h2000_0000, 32'h0001_0000,
                      32'h0000_0000, 32'h0004_0000, 32'h2000_0000, 32'h2002_0000);
      send_job(32'h2000_0000, 32'h0000_1000, 32'h2000_0000, 32'h0000_1000);
      send_job(32'h2000_1000, 32'h0000_1000, 32'h2000_0000, 32'h0001_0000);
      send_job(32'h2000_0800, 32'h0000_1000, 32'h2000_0400, 32'h0000_0400);
      send_job(32'h2000_0000, 32'h0000_1800, 32'h2000_0400, 32'h0000_0200);
      send_job(32'h2000_8000, 32'h0001_0000, 32'h2000_0000, 32'h0002_0000);
      send_job(32'h2000_0000, 32'h0000_0000, 32'h2000_0000, 32'd3000);
      send_job(32'h2000_FFE0, 32'h0000_0020, 32'h2000_0600, 32'h0000_0400);
      send_job(32'h0800_0010, 32'h0000_0030, 32'h2000_F000, 32'h0000_2000);
      send_job(32'h0800_0000, 32'h0000_0001, 32'h2000_FFFF, 32'h0000_0400);
      send_job(32'h080F_FFFF, 32'h0000_0001, 32'h3000_0000, 32'h0000_0000);
      send_job(32'h080F_FFF0, 32'h0000_0020, 32'h1FFF_FFFF, 32'h0000_0400);
      send_job(32'h0800_0000, 32'h0010_0000, 32'h2001_0000, 32'h0000_0400);
      send_job(32'h0800_0100, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

      // Shared base inside data windows, zero-sized kernel window
      program_setting(32'h0800_0000, 32'h0010_0000, 32'h2000_0000, 32'h0001_0000,
                      32'h0000_0000, 32'h0000_0000, 32'h2000_0000, 32'h2000_0400);
      send_job(32'h0000_0000, 32'h0000_0004, 32'h2000_0000, 32'h0001_0000);
      send_job(32'h2000_0400, 32'h0000_0400, 32'h2000_0400, 32'h0000_0400);
      send_job(32'h1234_5678, 32'h0000_0010, 32'h4000_0000, 32'h0000_0400);

      // Image pool straddling the 2 GiB line: oversized windows
      program_setting(32'h4000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000,
                      32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_job(32'h7FFF_FFF0, 32'h0000_0020, 32'h0000_0000, 32'h0000_0400);
      send_job(32'h4000_0000, 32'h4000_0000, 32'h8000_0000, 32'h0000_0400);
      send_job(32'hBFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000);

      // Pools reaching the top of the address space, all-ones kernel window
      program_setting(32'h8000_0000, 32'h8000_0000, 32'hFFFF_0000, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_job(32'h8000_0010, 32'h7FFF_FFF0, 32'hFFFF_0000, 32'h0001_0000);
      send_job(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
      send_job(32'h7FFF_FFFF, 32'h0000_0005, 32'h8000_0000, 32'h0000_0400);

      // Random settings, each with a batch of random task words
      for (int phase = 0; phase < 6; phase++) begin
         random_setting();
         for (int n = 0; n < 40; n++) begin
            if (n % 20 == 0) steady = ($urandom_range(0, 3) == 0);
            random_job();
         end
      end

      settle();
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule
